// ----- rtl/core/cpss_pkg.sv -----
package cpss_pkg;

  // Fixed field widths of the beats on the ports
  localparam int unsigned FIELD_BITS = 20;
  localparam int unsigned DIST_BITS  = 42;
  localparam int unsigned TOTAL_BITS = 63;

  localparam logic [DIST_BITS-1:0]  DIST_MAX  = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic                  start_req;
    logic [FIELD_BITS-1:0] px;
    logic [FIELD_BITS-1:0] py;
  } cpss_in_t;

  typedef struct packed {
    logic                  has_pair;
    logic [DIST_BITS-1:0]  min_dist_sq;
    logic [TOTAL_BITS-1:0] total;
    logic                  overflow;
  } cpss_out_t;

  // Control word that travels with a query along the cell chain
  typedef struct packed {
    logic vld;    // a query occupies this slot
    logic start;  // query opens a new case
    logic drop;   // store was full, query only reports
    logic sq_ok;  // squares carried alongside are a live comparison
  } cpss_ctl_t;

endpackage

// ----- rtl/core/cpss_cell.sv -----
module cpss_cell #(
  parameter int unsigned CW       = 20,
  parameter int unsigned IW       = 11,
  parameter int unsigned MW       = 42,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cpss_pkg::cpss_ctl_t ctl_i,
  input  logic [IW-1:0]       idx_i,
  input  logic [CW-1:0]       x_i,
  input  logic [CW-1:0]       y_i,
  input  logic [2*CW-1:0]     sqx_i,
  input  logic [2*CW-1:0]     sqy_i,
  input  logic [MW-1:0]       mn_i,
  output cpss_pkg::cpss_ctl_t ctl_o,
  output logic [IW-1:0]       idx_o,
  output logic [CW-1:0]       x_o,
  output logic [CW-1:0]       y_o,
  output logic [2*CW-1:0]     sqx_o,
  output logic [2*CW-1:0]     sqy_o,
  output logic [MW-1:0]       mn_o
);
  import cpss_pkg::*;

  localparam int unsigned SW = 2 * CW;

  logic [CW-1:0] pt_x_q, pt_y_q;
  logic [CW-1:0] dx, dy;
  logic [MW-1:0] dsum;
  logic          cmp, wr;

  cpss_ctl_t     ctl_d, ctl_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] x_q, y_q;
  logic [SW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic [MW-1:0] mn_d, mn_q;

  // Compare against the held point only if it belongs to this case
  assign cmp = ctl_i.vld && !ctl_i.drop && (idx_i > IW'(CELL_IDX));
  assign wr  = ctl_i.vld && !ctl_i.drop && (idx_i == IW'(CELL_IDX));

  always_comb begin
    dx    = (x_i > pt_x_q) ? (x_i - pt_x_q) : (pt_x_q - x_i);
    dy    = (y_i > pt_y_q) ? (y_i - pt_y_q) : (pt_y_q - y_i);
    sqx_d = SW'(dx) * SW'(dx);
    sqy_d = SW'(dy) * SW'(dy);
    // fold the squares handed over by the previous cell
    dsum  = MW'({1'b0, sqx_i} + {1'b0, sqy_i});
    mn_d  = (ctl_i.sq_ok && (dsum < mn_i)) ? dsum : mn_i;
    ctl_d       = ctl_i;
    ctl_d.sq_ok = cmp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q <= idx_i;
      x_q   <= x_i;
      y_q   <= y_i;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      mn_q  <= mn_d;
      if (wr) begin
        pt_x_q <= x_i;
        pt_y_q <= y_i;
      end
    end
  end

  assign ctl_o = ctl_q;
  assign idx_o = idx_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign sqx_o = sqx_q;
  assign sqy_o = sqy_q;
  assign mn_o  = mn_q;

endmodule

// ----- rtl/core/cpss_acc.sv -----
module cpss_acc #(
  parameter int unsigned CW = 20,
  parameter int unsigned IW = 11,
  parameter int unsigned MW = 42
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cpss_pkg::cpss_ctl_t ctl_i,
  input  logic [IW-1:0]       idx_i,
  input  logic [2*CW-1:0]     sqx_i,
  input  logic [2*CW-1:0]     sqy_i,
  input  logic [MW-1:0]       mn_i,
  output logic                out_valid_o,
  output cpss_pkg::cpss_out_t out_data_o
);
  import cpss_pkg::*;

  // Stage A: fold the last cell's squares into the query minimum
  cpss_ctl_t     a_ctl_q;
  logic          a_pair_q;
  logic [MW-1:0] a_mn_q;
  logic [MW-1:0] dsum, fmn;

  // Stage B: case minimum, running total, result register
  logic [DIST_BITS-1:0]  best_q, best_d, base_best;
  logic [TOTAL_BITS-1:0] total_q, total_d, base_total;
  logic [TOTAL_BITS:0]   sum;
  cpss_out_t             out_d, out_q;
  logic                  out_vld_q;

  always_comb begin
    dsum = MW'({1'b0, sqx_i} + {1'b0, sqy_i});
    fmn  = (ctl_i.sq_ok && (dsum < mn_i)) ? dsum : mn_i;
  end

  always_comb begin
    base_best  = a_ctl_q.start ? DIST_MAX : best_q;
    base_total = a_ctl_q.start ? '0 : total_q;
    best_d     = base_best;
    total_d    = base_total;
    sum        = '0;
    out_d      = '0;
    if (a_ctl_q.drop) begin
      // hold the case, report the full store
      out_d.has_pair    = 1'b1;
      out_d.min_dist_sq = best_q;
      out_d.total       = total_q;
      out_d.overflow    = 1'b1;
    end else begin
      if (a_mn_q < MW'(base_best)) begin
        best_d = DIST_BITS'(a_mn_q);
      end
      if (a_pair_q) begin
        sum     = {1'b0, base_total} + (TOTAL_BITS + 1)'(best_d);
        total_d = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      end
      out_d.has_pair    = a_pair_q;
      out_d.min_dist_sq = a_pair_q ? best_d : '0;
      out_d.total       = total_d;
      out_d.overflow    = (total_d == TOTAL_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q   <= '0;
      out_vld_q <= 1'b0;
      best_q    <= DIST_MAX;
      total_q   <= '0;
    end else if (en_i) begin
      a_ctl_q   <= ctl_i;
      out_vld_q <= a_ctl_q.vld;
      if (a_ctl_q.vld && !a_ctl_q.drop) begin
        best_q  <= best_d;
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pair_q <= (idx_i != '0);
      a_mn_q   <= fmn;
      out_q    <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/running_closest_pair_sum_unit.sv -----
// Running closest-pair sum over a stream of 2D points.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per point, with
// start_req opening a new case. Output channel (out_valid_o/out_ready_i/
// out_data_o): exactly one beat per input beat, in order, carrying the
// pair flag, the closest-pair squared distance, the saturating running
// total and the overflow flag.
// Each point is held in one cell of a chain of MAX_POINTS cells. A query
// steps one cell per cycle while the output is not stalled, and its result
// passes the entry register, the cells, stage A and the result register. Queries
// follow each other cell by cell, so one beat per cycle is taken and given
// when not stalled. A stall on the output freezes the whole chain and the
// input is not ready until the result register is drained; nothing is lost.
// Reset empties the case (count zero, minimum all ones, total zero); the
// points held in the cells need no clearing, as only points written in the
// current case are ever compared. A full store drops the point and reports
// overflow.
module running_closest_pair_sum_unit #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpss_pkg::cpss_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpss_pkg::cpss_out_t out_data_o
);
  import cpss_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned SW = 2 * CW;
  localparam int unsigned IW = $clog2(MAX_POINTS + 1);
  localparam int unsigned MW = (SW + 1 > DIST_BITS) ? SW + 1 : DIST_BITS;

  logic          en, accept, out_vld;
  logic [IW-1:0] cnt_q, idx_eff;
  logic          drop;

  // Entry register feeding cell 0
  cpss_ctl_t     e_ctl_q;
  logic [IW-1:0] e_idx_q;
  logic [CW-1:0] e_x_q, e_y_q;

  // Chain links: element i is the input of cell i
  cpss_ctl_t     c_ctl [0:MAX_POINTS];
  logic [IW-1:0] c_idx [0:MAX_POINTS];
  logic [SW-1:0] c_sqx [0:MAX_POINTS];
  logic [SW-1:0] c_sqy [0:MAX_POINTS];
  logic [MW-1:0] c_mn  [0:MAX_POINTS];
  logic [CW-1:0] c_x   [0:MAX_POINTS-1];
  logic [CW-1:0] c_y   [0:MAX_POINTS-1];

  // Advance the whole chain whenever the result register can take a beat
  assign en         = !out_vld || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // A start beat takes slot zero; otherwise the next free slot
  assign idx_eff = in_data_i.start_req ? '0 : cnt_q;
  assign drop    = !in_data_i.start_req && (cnt_q == IW'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      e_ctl_q <= '0;
    end else if (en) begin
      e_ctl_q.vld   <= in_valid_i;
      e_ctl_q.start <= in_data_i.start_req;
      e_ctl_q.drop  <= drop;
      e_ctl_q.sq_ok <= 1'b0;
      if (accept && !drop) begin
        cnt_q <= idx_eff + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_idx_q <= idx_eff;
      e_x_q   <= CW'(in_data_i.px);
      e_y_q   <= CW'(in_data_i.py);
    end
  end

  assign c_ctl[0] = e_ctl_q;
  assign c_idx[0] = e_idx_q;
  assign c_x[0]   = e_x_q;
  assign c_y[0]   = e_y_q;
  assign c_sqx[0] = '0;
  assign c_sqy[0] = '0;
  assign c_mn[0]  = '1;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i < MAX_POINTS - 1) begin : g_mid
      cpss_cell #(.CW(CW), .IW(IW), .MW(MW), .CELL_IDX(i)) u_cell (
        .clk_i, .rst_ni, .en_i(en),
        .ctl_i(c_ctl[i]), .idx_i(c_idx[i]), .x_i(c_x[i]), .y_i(c_y[i]),
        .sqx_i(c_sqx[i]), .sqy_i(c_sqy[i]), .mn_i(c_mn[i]),
        .ctl_o(c_ctl[i+1]), .idx_o(c_idx[i+1]), .x_o(c_x[i+1]), .y_o(c_y[i+1]),
        .sqx_o(c_sqx[i+1]), .sqy_o(c_sqy[i+1]), .mn_o(c_mn[i+1])
      );
    end else begin : g_last
      cpss_cell #(.CW(CW), .IW(IW), .MW(MW), .CELL_IDX(i)) u_cell (
        .clk_i, .rst_ni, .en_i(en),
        .ctl_i(c_ctl[i]), .idx_i(c_idx[i]), .x_i(c_x[i]), .y_i(c_y[i]),
        .sqx_i(c_sqx[i]), .sqy_i(c_sqy[i]), .mn_i(c_mn[i]),
        .ctl_o(c_ctl[i+1]), .idx_o(c_idx[i+1]), .x_o(), .y_o(),
        .sqx_o(c_sqx[i+1]), .sqy_o(c_sqy[i+1]), .mn_o(c_mn[i+1])
      );
    end
  end

  cpss_acc #(.CW(CW), .IW(IW), .MW(MW)) u_acc (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(c_ctl[MAX_POINTS]), .idx_i(c_idx[MAX_POINTS]),
    .sqx_i(c_sqx[MAX_POINTS]), .sqy_i(c_sqy[MAX_POINTS]),
    .mn_i(c_mn[MAX_POINTS]),
    .out_valid_o(out_vld), .out_data_o(out_data_o)
  );

  assign out_valid_o = out_vld;

  // A start beat always leaves exactly one point in the case
  a_start_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.start_req) |=> (cnt_q == IW'(1)))
    else $error("count not one after start beat");

  // A dropped point must not move the fill count
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && drop) |=> (cnt_q == IW'(MAX_POINTS)))
    else $error("fill count moved on dropped point");

  // Without a pair, nothing may have been accumulated
  a_no_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld && !out_data_o.has_pair) |->
      (out_data_o.min_dist_sq == '0 && out_data_o.total == '0))
    else $error("distance or total reported without a pair");

endmodule
